[hdl/cma_pkg.sv]
// Shared types, constants and saturation helper for the monodromy apply block.
`timescale 1ns / 1ps

package cma_pkg;

    localparam int WORD_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int OPCODE_W   = 3;
    localparam int CFG_IDX_W  = 2;

    localparam int PROD_W = 2 * WORD_WIDTH;
    localparam int ACC_W  = PROD_W + 1;
    localparam int TERM_W = (ACC_W - FRAC_BITS > WORD_WIDTH + 3) ?
                            (ACC_W - FRAC_BITS) : (WORD_WIDTH + 3);
    localparam int SUM_W  = TERM_W + 1;

    localparam logic signed [ACC_W-1:0] ROUND_HALF =
        {{(ACC_W-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
    localparam logic signed [SUM_W-1:0] SAT_MAX =
        {{(SUM_W-WORD_WIDTH+1){1'b0}}, {(WORD_WIDTH-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SAT_MIN =
        {{(SUM_W-WORD_WIDTH+1){1'b1}}, {(WORD_WIDTH-1){1'b0}}};

    localparam logic [OPCODE_W-1:0] OP_M0      = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_M1      = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_MINF    = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_M0INV   = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_M1INV   = 3'd4;
    localparam logic [OPCODE_W-1:0] OP_MINFINV = 3'd5;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_A_RE = 2'd0,
        CFG_A_IM = 2'd1,
        CFG_B_RE = 2'd2,
        CFG_B_IM = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        K_PASS,
        K_M0,
        K_M0INV,
        K_MINF,
        K_MINFINV
    } t_kind;

    typedef logic signed [WORD_WIDTH-1:0] t_word;

    typedef struct packed {
        t_word [3:0] re;
        t_word [3:0] im;
    } t_cvec;

    typedef struct packed {
        t_word a_re;
        t_word a_im;
        t_word b_re;
        t_word b_im;
    } t_coef;

    typedef struct packed {
        t_cvec x;
        t_kind op_b;
        logic  sat;
        logic  last;
    } t_item;

    typedef struct packed {
        t_word w;
        logic  clip;
    } t_sat;

    function automatic t_sat sat_word(input logic signed [SUM_W-1:0] v);
        t_sat r;
        r.clip = 1'b1;
        if (v > SAT_MAX) begin
            r.w = SAT_MAX[WORD_WIDTH-1:0];
        end else if (v < SAT_MIN) begin
            r.w = SAT_MIN[WORD_WIDTH-1:0];
        end else begin
            r.w    = v[WORD_WIDTH-1:0];
            r.clip = 1'b0;
        end
        return r;
    endfunction

endpackage

[hdl/cy_monodromy_apply.sv]
// Top level: coefficient registers, opcode decode and two monodromy stages in series.
`timescale 1ns / 1ps

// Applies M0, M1, Minf, an inverse of one of them, or a pass to a complex
// 4-vector in Q16.16. The block takes one vector per cycle while the output
// is not stalled: two identical three-stage units (products, rounding, add
// and saturate) run in series, and each opcode uses the first unit or both,
// an undefined opcode neither; eight 32x32 multipliers per unit set the
// depth of its first stage. Results leave in order; a stall on the output
// backs up through the pipeline without loss.
// Write the coefficients only while no vector is in flight.
module cy_monodromy_apply (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    input  logic                            i_cfg_we,
    input  logic [cma_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [cma_pkg::WORD_WIDTH-1:0]  i_cfg_data,

    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [cma_pkg::OPCODE_W-1:0]    i_opcode,
    input  logic signed [cma_pkg::WORD_WIDTH-1:0] i_in0_re,
    input  logic signed [cma_pkg::WORD_WIDTH-1:0] i_in0_im,
    input  logic signed [cma_pkg::WORD_WIDTH-1:0] i_in1_re,
    input  logic signed [cma_pkg::WORD_WIDTH-1:0] i_in1_im,
    input  logic signed [cma_pkg::WORD_WIDTH-1:0] i_in2_re,
    input  logic signed [cma_pkg::WORD_WIDTH-1:0] i_in2_im,
    input  logic signed [cma_pkg::WORD_WIDTH-1:0] i_in3_re,
    input  logic signed [cma_pkg::WORD_WIDTH-1:0] i_in3_im,
    input  logic                            i_in_last,

    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic signed [cma_pkg::WORD_WIDTH-1:0] o_out0_re,
    output logic signed [cma_pkg::WORD_WIDTH-1:0] o_out0_im,
    output logic signed [cma_pkg::WORD_WIDTH-1:0] o_out1_re,
    output logic signed [cma_pkg::WORD_WIDTH-1:0] o_out1_im,
    output logic signed [cma_pkg::WORD_WIDTH-1:0] o_out2_re,
    output logic signed [cma_pkg::WORD_WIDTH-1:0] o_out2_im,
    output logic signed [cma_pkg::WORD_WIDTH-1:0] o_out3_re,
    output logic signed [cma_pkg::WORD_WIDTH-1:0] o_out3_im,
    output logic                            o_saturated,
    output logic                            o_out_last
);

    cma_pkg::t_coef r_coef, n_coef;
    cma_pkg::t_kind kind_a, kind_b;
    cma_pkg::t_item in_item;
    cma_pkg::t_item a_item, b_item;
    logic           a_valid, a_ready;

    always_comb begin
        n_coef = r_coef;
        if (i_cfg_we) begin
            unique case (cma_pkg::t_cfg_idx'(i_cfg_idx))
                cma_pkg::CFG_A_RE: n_coef.a_re = i_cfg_data;
                cma_pkg::CFG_A_IM: n_coef.a_im = i_cfg_data;
                cma_pkg::CFG_B_RE: n_coef.b_re = i_cfg_data;
                cma_pkg::CFG_B_IM: n_coef.b_im = i_cfg_data;
                default:           n_coef = r_coef;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef <= '0;
        end else begin
            r_coef <= n_coef;
        end
    end

    always_comb begin
        unique case (i_opcode)
            cma_pkg::OP_M0: begin
                kind_a = cma_pkg::K_M0;
                kind_b = cma_pkg::K_PASS;
            end
            cma_pkg::OP_M1: begin
                kind_a = cma_pkg::K_MINFINV;
                kind_b = cma_pkg::K_M0INV;
            end
            cma_pkg::OP_MINF: begin
                kind_a = cma_pkg::K_MINF;
                kind_b = cma_pkg::K_PASS;
            end
            cma_pkg::OP_M0INV: begin
                kind_a = cma_pkg::K_M0INV;
                kind_b = cma_pkg::K_PASS;
            end
            cma_pkg::OP_M1INV: begin
                kind_a = cma_pkg::K_M0;
                kind_b = cma_pkg::K_MINF;
            end
            cma_pkg::OP_MINFINV: begin
                kind_a = cma_pkg::K_MINFINV;
                kind_b = cma_pkg::K_PASS;
            end
            default: begin
                kind_a = cma_pkg::K_PASS;
                kind_b = cma_pkg::K_PASS;
            end
        endcase
    end

    always_comb begin
        in_item.x.re[0] = i_in0_re;
        in_item.x.im[0] = i_in0_im;
        in_item.x.re[1] = i_in1_re;
        in_item.x.im[1] = i_in1_im;
        in_item.x.re[2] = i_in2_re;
        in_item.x.im[2] = i_in2_im;
        in_item.x.re[3] = i_in3_re;
        in_item.x.im[3] = i_in3_im;
        in_item.op_b    = kind_b;
        in_item.sat     = 1'b0;
        in_item.last    = i_in_last;
    end

    cma_stage u_stage_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_coef  (r_coef),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_kind  (kind_a),
        .i_item  (in_item),
        .o_valid (a_valid),
        .i_ready (a_ready),
        .o_item  (a_item)
    );

    cma_stage u_stage_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_coef  (r_coef),
        .i_valid (a_valid),
        .o_ready (a_ready),
        .i_kind  (a_item.op_b),
        .i_item  (a_item),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (b_item)
    );

    assign o_out0_re   = b_item.x.re[0];
    assign o_out0_im   = b_item.x.im[0];
    assign o_out1_re   = b_item.x.re[1];
    assign o_out1_im   = b_item.x.im[1];
    assign o_out2_re   = b_item.x.re[2];
    assign o_out2_im   = b_item.x.im[2];
    assign o_out3_re   = b_item.x.re[3];
    assign o_out3_im   = b_item.x.im[3];
    assign o_saturated = b_item.sat;
    assign o_out_last  = b_item.last;

endmodule

[hdl/cma_stage.sv]
// One monodromy stage: product, round-and-select, add-and-saturate pipeline.
`timescale 1ns / 1ps

module cma_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  cma_pkg::t_coef i_coef,
    input  logic           i_valid,
    output logic           o_ready,
    input  cma_pkg::t_kind i_kind,
    input  cma_pkg::t_item i_item,
    output logic           o_valid,
    input  logic           i_ready,
    output cma_pkg::t_item o_item
);

    logic ce1, ce2, ce3;
    logic r1_v, r2_v, r3_v;

    logic           n1_fwd;
    cma_pkg::t_word n1_vr, n1_vi;

    cma_pkg::t_item r1_item;
    cma_pkg::t_kind r1_kind;
    logic           r1_fwd;
    logic signed [cma_pkg::PROD_W-1:0] r1_ar_vr, r1_ai_vi, r1_ar_vi, r1_ai_vr;
    logic signed [cma_pkg::PROD_W-1:0] r1_br_vr, r1_bi_vi, r1_br_vi, r1_bi_vr;

    logic signed [cma_pkg::ACC_W-1:0]  s_ar, s_ai, s_br, s_bi;
    logic signed [cma_pkg::TERM_W-1:0] t_ext_re, t_ext_im;
    logic signed [cma_pkg::TERM_W-1:0] n2_c0_re, n2_c0_im, n2_c1_re, n2_c1_im;
    cma_pkg::t_word n2_vr, n2_vi;
    logic           n2_int;

    cma_pkg::t_item r2_item;
    cma_pkg::t_kind r2_kind;
    logic           r2_fwd;
    logic signed [cma_pkg::TERM_W-1:0] r2_c0_re, r2_c0_im, r2_c1_re, r2_c1_im;

    logic signed [cma_pkg::SUM_W-1:0] s_re [4];
    logic signed [cma_pkg::SUM_W-1:0] s_im [4];
    cma_pkg::t_sat  q_re [4];
    cma_pkg::t_sat  q_im [4];
    cma_pkg::t_item n3_item;

    cma_pkg::t_item r3_item;

    assign ce3     = !r3_v || i_ready;
    assign ce2     = !r2_v || ce3;
    assign ce1     = !r1_v || ce2;
    assign o_ready = ce1;
    assign o_valid = r3_v;
    assign o_item  = r3_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else begin
            if (ce1) begin
                r1_v <= i_valid;
            end
            if (ce2) begin
                r2_v <= r1_v;
            end
            if (ce3) begin
                r3_v <= r2_v;
            end
        end
    end

    // select the source coordinate and form the eight partial products
    assign n1_fwd = (i_kind == cma_pkg::K_M0) || (i_kind == cma_pkg::K_MINFINV);
    assign n1_vr  = n1_fwd ? i_item.x.re[0] : i_item.x.re[3];
    assign n1_vi  = n1_fwd ? i_item.x.im[0] : i_item.x.im[3];

    always_ff @(posedge i_clk) begin
        if (ce1 && i_valid) begin
            r1_item  <= i_item;
            r1_kind  <= i_kind;
            r1_fwd   <= n1_fwd;
            r1_ar_vr <= cma_pkg::PROD_W'($signed(i_coef.a_re))
                        * cma_pkg::PROD_W'($signed(n1_vr));
            r1_ai_vi <= cma_pkg::PROD_W'($signed(i_coef.a_im))
                        * cma_pkg::PROD_W'($signed(n1_vi));
            r1_ar_vi <= cma_pkg::PROD_W'($signed(i_coef.a_re))
                        * cma_pkg::PROD_W'($signed(n1_vi));
            r1_ai_vr <= cma_pkg::PROD_W'($signed(i_coef.a_im))
                        * cma_pkg::PROD_W'($signed(n1_vr));
            r1_br_vr <= cma_pkg::PROD_W'($signed(i_coef.b_re))
                        * cma_pkg::PROD_W'($signed(n1_vr));
            r1_bi_vi <= cma_pkg::PROD_W'($signed(i_coef.b_im))
                        * cma_pkg::PROD_W'($signed(n1_vi));
            r1_br_vi <= cma_pkg::PROD_W'($signed(i_coef.b_re))
                        * cma_pkg::PROD_W'($signed(n1_vi));
            r1_bi_vr <= cma_pkg::PROD_W'($signed(i_coef.b_im))
                        * cma_pkg::PROD_W'($signed(n1_vr));
        end
    end

    // round the complex products, build the integer terms, pick one set
    always_comb begin
        s_ar = cma_pkg::ACC_W'(r1_ar_vr) - cma_pkg::ACC_W'(r1_ai_vi) + cma_pkg::ROUND_HALF;
        s_ai = cma_pkg::ACC_W'(r1_ar_vi) + cma_pkg::ACC_W'(r1_ai_vr) + cma_pkg::ROUND_HALF;
        s_br = cma_pkg::ACC_W'(r1_br_vr) - cma_pkg::ACC_W'(r1_bi_vi) + cma_pkg::ROUND_HALF;
        s_bi = cma_pkg::ACC_W'(r1_br_vi) + cma_pkg::ACC_W'(r1_bi_vr) + cma_pkg::ROUND_HALF;

        n2_vr    = r1_fwd ? r1_item.x.re[0] : r1_item.x.re[3];
        n2_vi    = r1_fwd ? r1_item.x.im[0] : r1_item.x.im[3];
        t_ext_re = cma_pkg::TERM_W'($signed(n2_vr));
        t_ext_im = cma_pkg::TERM_W'($signed(n2_vi));
        n2_int   = (r1_kind == cma_pkg::K_M0) || (r1_kind == cma_pkg::K_M0INV);

        if (n2_int) begin
            n2_c0_re = t_ext_re <<< 2;
            n2_c0_im = t_ext_im <<< 2;
            n2_c1_re = -((t_ext_re <<< 2) + (t_ext_re <<< 1));
            n2_c1_im = -((t_ext_im <<< 2) + (t_ext_im <<< 1));
        end else begin
            n2_c0_re = cma_pkg::TERM_W'(s_ar >>> cma_pkg::FRAC_BITS);
            n2_c0_im = cma_pkg::TERM_W'(s_ai >>> cma_pkg::FRAC_BITS);
            n2_c1_re = cma_pkg::TERM_W'(s_br >>> cma_pkg::FRAC_BITS);
            n2_c1_im = cma_pkg::TERM_W'(s_bi >>> cma_pkg::FRAC_BITS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce2 && r1_v) begin
            r2_item  <= r1_item;
            r2_kind  <= r1_kind;
            r2_fwd   <= r1_fwd;
            r2_c0_re <= n2_c0_re;
            r2_c0_im <= n2_c0_im;
            r2_c1_re <= n2_c1_re;
            r2_c1_im <= n2_c1_im;
        end
    end

    // shift the vector, add the terms, saturate every part unless the kind is a pass
    always_comb begin
        if (r2_fwd) begin
            for (int k = 0; k < 3; k++) begin
                s_re[k] = cma_pkg::SUM_W'($signed(r2_item.x.re[k+1]))
                          + cma_pkg::SUM_W'((k == 1) ? r2_c1_re : r2_c0_re);
                s_im[k] = cma_pkg::SUM_W'($signed(r2_item.x.im[k+1]))
                          + cma_pkg::SUM_W'((k == 1) ? r2_c1_im : r2_c0_im);
            end
            s_re[3] = -cma_pkg::SUM_W'($signed(r2_item.x.re[0]));
            s_im[3] = -cma_pkg::SUM_W'($signed(r2_item.x.im[0]));
        end else begin
            s_re[0] = -cma_pkg::SUM_W'($signed(r2_item.x.re[3]));
            s_im[0] = -cma_pkg::SUM_W'($signed(r2_item.x.im[3]));
            for (int k = 0; k < 3; k++) begin
                s_re[k+1] = cma_pkg::SUM_W'($signed(r2_item.x.re[k]))
                            + cma_pkg::SUM_W'((k == 1) ? r2_c1_re : r2_c0_re);
                s_im[k+1] = cma_pkg::SUM_W'($signed(r2_item.x.im[k]))
                            + cma_pkg::SUM_W'((k == 1) ? r2_c1_im : r2_c0_im);
            end
        end

        n3_item = r2_item;
        for (int k = 0; k < 4; k++) begin
            q_re[k] = cma_pkg::sat_word(s_re[k]);
            q_im[k] = cma_pkg::sat_word(s_im[k]);
            if (r2_kind != cma_pkg::K_PASS) begin
                n3_item.x.re[k] = q_re[k].w;
                n3_item.x.im[k] = q_im[k].w;
                n3_item.sat     = n3_item.sat | q_re[k].clip | q_im[k].clip;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce3 && r2_v) begin
            r3_item <= n3_item;
        end
    end

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !r1_v && !r2_v && !r3_v)
        else $error("pipeline not empty after reset");

    a_mid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r2_v && !ce3 |=> r2_v && $stable(r2_item) && $stable(r2_c0_re) && $stable(r2_c1_re))
        else $error("stalled middle stage changed");

    a_flag_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r2_v && ce3 && r2_item.sat |=> r3_item.sat)
        else $error("saturation flag from earlier stage dropped");

    a_pass_exact: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r2_v && ce3 && r2_kind == cma_pkg::K_PASS |=> r3_item.x == $past(r2_item.x))
        else $error("pass stage altered the vector");

endmodule

[tb/sv/cy_monodromy_apply_test.sv]
// Self-checking testbench for cy_monodromy_apply with a predicting scoreboard.
`timescale 1ns / 1ps

package cma_check_pkg;
    import cma_pkg::*;

    typedef logic signed [79:0] t_wide;

    typedef struct {
        longint re[4];
        longint im[4];
        bit     sat;
        bit     last;
    } t_vec;

    class monodromy_board;
        longint a_re, a_im, b_re, b_im;
        t_vec   predicted_q[$];
        int     errors;
        int     results_seen;

        function new();
            a_re = 0;
            a_im = 0;
            b_re = 0;
            b_im = 0;
            errors = 0;
            results_seen = 0;
        endfunction

        function void set_coef(t_cfg_idx idx, t_word data);
            case (idx)
                CFG_A_RE: a_re = longint'(data);
                CFG_A_IM: a_im = longint'(data);
                CFG_B_RE: b_re = longint'(data);
                CFG_B_IM: b_im = longint'(data);
            endcase
        endfunction

        function t_wide round_part(t_wide p, t_wide q, t_wide r, t_wide s, bit sub);
            t_wide acc;
            t_wide half;
            half = t_wide'(1) <<< (FRAC_BITS - 1);
            acc  = sub ? p * q - r * s : p * q + r * s;
            return (acc + half) >>> FRAC_BITS;
        endfunction

        function longint clamp_part(t_wide v);
            t_wide hi;
            t_wide lo;
            hi = (t_wide'(1) <<< (WORD_WIDTH - 1)) - 1;
            lo = -hi - 1;
            if (v > hi) return longint'(hi);
            if (v < lo) return longint'(lo);
            return longint'(v);
        endfunction

        function t_vec stage(t_kind kind, t_vec x);
            t_vec  y;
            t_wide vr, vi;
            t_wide cr[3], ci[3], wr[4], wi[4];
            int    src;
            int    k;
            src = (kind == K_M0 || kind == K_MINFINV) ? 0 : 3;
            vr  = t_wide'(x.re[src]);
            vi  = t_wide'(x.im[src]);
            if (kind == K_M0 || kind == K_M0INV) begin
                cr[0] = 4 * vr;
                ci[0] = 4 * vi;
                cr[1] = -6 * vr;
                ci[1] = -6 * vi;
                cr[2] = 4 * vr;
                ci[2] = 4 * vi;
            end else begin
                cr[0] = round_part(t_wide'(a_re), vr, t_wide'(a_im), vi, 1'b1);
                ci[0] = round_part(t_wide'(a_re), vi, t_wide'(a_im), vr, 1'b0);
                cr[1] = round_part(t_wide'(b_re), vr, t_wide'(b_im), vi, 1'b1);
                ci[1] = round_part(t_wide'(b_re), vi, t_wide'(b_im), vr, 1'b0);
                cr[2] = cr[0];
                ci[2] = ci[0];
            end
            if (src == 0) begin
                for (k = 0; k < 3; k++) begin
                    wr[k] = x.re[k + 1] + cr[k];
                    wi[k] = x.im[k + 1] + ci[k];
                end
                wr[3] = -vr;
                wi[3] = -vi;
            end else begin
                wr[0] = -vr;
                wi[0] = -vi;
                for (k = 0; k < 3; k++) begin
                    wr[k + 1] = x.re[k] + cr[k];
                    wi[k + 1] = x.im[k] + ci[k];
                end
            end
            y.sat  = x.sat;
            y.last = x.last;
            for (k = 0; k < 4; k++) begin
                y.re[k] = clamp_part(wr[k]);
                y.im[k] = clamp_part(wi[k]);
                if (y.re[k] != wr[k] || y.im[k] != wi[k]) y.sat = 1'b1;
            end
            return y;
        endfunction

        function void note_request(logic [OPCODE_W-1:0] op, t_vec x);
            t_vec y;
            x.sat = 1'b0;
            case (op)
                OP_M0:      y = stage(K_M0, x);
                OP_M1:      y = stage(K_M0INV, stage(K_MINFINV, x));
                OP_MINF:    y = stage(K_MINF, x);
                OP_M0INV:   y = stage(K_M0INV, x);
                OP_M1INV:   y = stage(K_MINF, stage(K_M0, x));
                OP_MINFINV: y = stage(K_MINFINV, x);
                default:    y = x;
            endcase
            predicted_q.push_back(y);
        endfunction

        task report(string msg);
            errors++;
            $display("%0t: %s", $time, msg);
        endtask

        task check_result(t_vec got);
            t_vec w;
            int   k;
            if (predicted_q.size() == 0) begin
                report($sformatf("result %0d arrived with no request pending", results_seen));
            end else begin
                w = predicted_q.pop_front();
                for (k = 0; k < 4; k++) begin
                    if (got.re[k] != w.re[k])
                        report($sformatf("result %0d: out%0d_re %0d, predicted %0d",
                                         results_seen, k, got.re[k], w.re[k]));
                    if (got.im[k] != w.im[k])
                        report($sformatf("result %0d: out%0d_im %0d, predicted %0d",
                                         results_seen, k, got.im[k], w.im[k]));
                end
                if (got.sat != w.sat)
                    report($sformatf("result %0d: saturated %0d, predicted %0d",
                                     results_seen, got.sat, w.sat));
                if (got.last != w.last)
                    report($sformatf("result %0d: out_last %0d, predicted %0d",
                                     results_seen, got.last, w.last));
            end
            results_seen++;
        endtask

        function int outstanding();
            return predicted_q.size();
        endfunction
    endclass

endpackage

module cy_monodromy_apply_test;
    import cma_pkg::*;
    import cma_check_pkg::*;

    localparam t_word W_MAX = {1'b0, {(WORD_WIDTH-1){1'b1}}};
    localparam t_word W_MIN = {1'b1, {(WORD_WIDTH-1){1'b0}}};
    localparam int    PHASES = 8;
    localparam int    PHASE_ITEMS = 160;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    t_cfg_idx             i_cfg_idx = CFG_A_RE;
    logic [WORD_WIDTH-1:0] i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic [OPCODE_W-1:0]  i_opcode = '0;
    t_word                vec_re[4] = '{default: '0};
    t_word                vec_im[4] = '{default: '0};
    logic                 i_in_last = 1'b0;
    logic                 i_out_ready = 1'b0;
    logic                 o_in_ready;
    logic                 o_out_valid;
    wire signed [WORD_WIDTH-1:0] res_re[4];
    wire signed [WORD_WIDTH-1:0] res_im[4];
    logic                 o_saturated;
    logic                 o_out_last;

    logic [15:0]          ready_mask = 16'hffff;
    logic [3:0]           ready_pos = '0;
    int                   burst_left = 0;
    bit                   gaps_on = 1'b1;

    monodromy_board board;

    cy_monodromy_apply i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_opcode    (i_opcode),
        .i_in0_re    (vec_re[0]),
        .i_in0_im    (vec_im[0]),
        .i_in1_re    (vec_re[1]),
        .i_in1_im    (vec_im[1]),
        .i_in2_re    (vec_re[2]),
        .i_in2_im    (vec_im[2]),
        .i_in3_re    (vec_re[3]),
        .i_in3_im    (vec_im[3]),
        .i_in_last   (i_in_last),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out0_re   (res_re[0]),
        .o_out0_im   (res_im[0]),
        .o_out1_re   (res_re[1]),
        .o_out1_im   (res_im[1]),
        .o_out2_re   (res_re[2]),
        .o_out2_im   (res_im[2]),
        .o_out3_re   (res_re[3]),
        .o_out3_im   (res_im[3]),
        .o_saturated (o_saturated),
        .o_out_last  (o_out_last)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        t_vec got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            for (int k = 0; k < 4; k++) begin
                got.re[k] = longint'(res_re[k]);
                got.im[k] = longint'(res_im[k]);
            end
            got.sat  = o_saturated;
            got.last = o_out_last;
            board.check_result(got);
        end
        ready_pos   <= ready_pos + 4'd1;
        i_out_ready <= ready_mask[ready_pos];
        if (ready_pos == 4'd15 && $urandom_range(0, 15) == 0) begin
            case ($urandom_range(0, 2))
                0:       ready_mask <= '1;
                1:       ready_mask <= 16'($urandom) | 16'h0001;
                default: ready_mask <= 16'($urandom | $urandom) | 16'h0001;
            endcase
        end
    end

    initial begin
        #3_000_000;
        $display("cy_monodromy_apply_test: FAIL");
        $finish;
    end

    function automatic t_word pick_word();
        case ($urandom_range(0, 9))
            0, 1, 2: return t_word'($urandom);
            3:       return W_MAX;
            4:       return W_MIN;
            5:       return t_word'($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
            default: return t_word'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
        endcase
    endfunction

    function automatic t_vec pick_vec();
        t_vec v;
        for (int k = 0; k < 4; k++) begin
            v.re[k] = longint'(pick_word());
            v.im[k] = longint'(pick_word());
        end
        v.sat  = 1'b0;
        v.last = 1'($urandom_range(0, 1));
        return v;
    endfunction

    function automatic t_vec flat_vec(t_word w, bit last);
        t_vec v;
        for (int k = 0; k < 4; k++) begin
            v.re[k] = longint'(w);
            v.im[k] = longint'(w);
        end
        v.sat  = 1'b0;
        v.last = last;
        return v;
    endfunction

    task automatic pause(int cycles);
        i_in_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic drain();
        pause(1);
        while (board.outstanding() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_coef(t_cfg_idx idx, t_word data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        board.set_coef(idx, data);
        @(posedge i_clk);
    endtask

    task automatic load_coefs(t_word ar, t_word ai, t_word br, t_word bi);
        drain();
        write_coef(CFG_A_RE, ar);
        write_coef(CFG_A_IM, ai);
        write_coef(CFG_B_RE, br);
        write_coef(CFG_B_IM, bi);
    endtask

    task automatic send_vector(logic [OPCODE_W-1:0] op, t_vec x);
        i_in_valid <= 1'b1;
        i_opcode   <= op;
        for (int k = 0; k < 4; k++) begin
            vec_re[k] <= t_word'(x.re[k]);
            vec_im[k] <= t_word'(x.im[k]);
        end
        i_in_last <= x.last;
        do @(posedge i_clk); while (!o_in_ready);
        board.note_request(op, x);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 40);
            if (gaps_on) pause($urandom_range(1, 6));
        end
    endtask

    initial begin
        t_word coef_table[5][4];
        t_vec  ramp;
        coef_table = '{
            '{32'sh0001_0000, 32'sh0, 32'sh0, 32'sh0001_0000},
            '{W_MAX, W_MIN, W_MIN, W_MAX},
            '{W_MIN, W_MIN, W_MAX, W_MAX},
            '{32'sh0, 32'sh0, 32'sh0, 32'sh0},
            '{-32'sh0001_0000, 32'sh0000_8000, 32'sh0004_0000, -32'sh1}
        };
        board = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        load_coefs(32'sh0001_8000, -32'sh0000_4000, -32'sh0002_0000, 32'sh0000_C000);
        for (int k = 0; k < 4; k++) begin
            ramp.re[k] = longint'((k + 1) * 65536);
            ramp.im[k] = longint'(-(k + 1) * 32768);
        end
        ramp.sat = 1'b0;
        for (int op = 0; op < 8; op++) begin
            ramp.last = (op == 7);
            send_vector(OPCODE_W'(op), ramp);
            send_vector(OPCODE_W'(op), flat_vec(W_MIN, op[0]));
            send_vector(OPCODE_W'(op), flat_vec(W_MAX, op[1]));
        end

        for (int p = 0; p < PHASES; p++) begin
            if (p < 5) begin
                load_coefs(coef_table[p][0], coef_table[p][1],
                           coef_table[p][2], coef_table[p][3]);
            end else if (p == 6) begin
                load_coefs(t_word'($urandom), t_word'($urandom),
                           t_word'($urandom), t_word'($urandom));
            end else begin
                load_coefs(t_word'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000,
                           t_word'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000,
                           t_word'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000,
                           t_word'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
            end
            gaps_on = (p % 3 != 1);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // hold off mid-phase until the output side is empty
                if (n == PHASE_ITEMS / 2) drain();
                send_vector(OPCODE_W'($urandom_range(0, 7)), pick_vec());
            end
        end

        pause(1);
        while (board.outstanding() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (board.errors == 0) begin
            $display("cy_monodromy_apply_test: PASS");
        end else begin
            $display("cy_monodromy_apply_test: FAIL");
        end
        $finish;
    end

endmodule
